### hdl/rc2p_pkg.sv
// shared constants and types for the relativistic conserved-to-primitive block
// no dependencies
`default_nettype none
package rc2p_pkg;

    localparam int FRAC_BITS = 32;
    localparam logic signed [63:0] ONE_FX = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] FX_MIN = 64'sh8000_0000_0000_0000;

    // shared unit operations
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_SUB  = 3'd1;
    localparam logic [2:0] OP_MUL  = 3'd2;
    localparam logic [2:0] OP_DIV  = 3'd3;
    localparam logic [2:0] OP_SQRT = 3'd4;
    localparam logic [2:0] OP_HALF = 3'd5;

    // configuration register indexes
    localparam logic CFG_TOL   = 1'b0;
    localparam logic CFG_MAXIT = 1'b1;

    typedef struct packed {
        logic       start;
        logic [2:0] op;
    } t_alu_req;

endpackage
`default_nettype wire

### hdl/rc2p_alu.sv
// shared fixed point unit: saturating add/sub/halve, 4-step multiply,
// bit-serial divide (128 steps) and square root (48 steps); uses rc2p_pkg
`default_nettype none
module rc2p_alu
    import rc2p_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_alu_req           i_req,
    input  wire logic signed [63:0] i_a,
    input  wire logic signed [63:0] i_b,
    output logic                    o_done,
    output logic signed [63:0]      o_res
);

    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic [2:0]   r_op, n_op;
    logic [7:0]   r_cnt, n_cnt;
    logic         r_neg, n_neg;
    logic [63:0]  r_ma, n_ma;
    logic [63:0]  r_mb, n_mb;
    logic [127:0] r_acc, n_acc;
    logic [63:0]  r_rem, n_rem;
    logic [51:0]  r_srem, n_srem;
    logic [63:0]  r_q, n_q;
    logic         r_ovf, n_ovf;
    logic signed [63:0] r_res, n_res;

    logic [63:0]  w_mag_a, w_mag_b;
    logic [64:0]  w_sum;
    logic [63:0]  w_prod;
    logic [127:0] w_pp;
    logic [64:0]  w_r2;
    logic         w_ge;
    logic [51:0]  w_sh, w_trial;

    function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m,
                                                     input logic ovf);
        logic signed [63:0] v;
        if (ovf || m[63]) begin
            v = neg ? FX_MIN : FX_MAX;
        end else begin
            v = neg ? -$signed(m) : $signed(m);
        end
        return v;
    endfunction

    always_comb begin
        w_mag_a = i_a[63] ? 64'(-i_a) : 64'(i_a);
        w_mag_b = i_b[63] ? 64'(-i_b) : 64'(i_b);
        w_sum   = 65'd0;
        w_prod  = (r_cnt[1] ? r_ma[63:32] : r_ma[31:0]) * (r_cnt[0] ? r_mb[63:32] : r_mb[31:0]);
        case ({1'b0, r_cnt[1]} + {1'b0, r_cnt[0]})
            2'd0:    w_pp = {64'd0, w_prod};
            2'd1:    w_pp = {32'd0, w_prod, 32'd0};
            default: w_pp = {w_prod, 64'd0};
        endcase
        w_r2    = {r_rem, r_acc[127]};
        w_ge    = w_r2 >= {1'b0, r_mb};
        w_sh    = {r_srem[49:0], r_acc[95:94]};
        w_trial = {2'b00, r_q[47:0], 2'b01};

        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_ma   = r_ma;
        n_mb   = r_mb;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_srem = r_srem;
        n_q    = r_q;
        n_ovf  = r_ovf;
        n_res  = r_res;

        if (!r_busy && i_req.start) begin
            n_op  = i_req.op;
            n_cnt = 8'd0;
            n_neg = i_a[63] ^ i_b[63];
            n_ma  = w_mag_a;
            n_mb  = w_mag_b;
            n_rem = 64'd0;
            n_srem = 52'd0;
            n_q   = 64'd0;
            n_ovf = 1'b0;
            case (i_req.op)
                OP_ADD, OP_SUB: begin
                    if (i_req.op == OP_ADD) begin
                        w_sum = {i_a[63], i_a} + {i_b[63], i_b};
                    end else begin
                        w_sum = {i_a[63], i_a} - {i_b[63], i_b};
                    end
                    if (w_sum[64] != w_sum[63]) begin
                        n_res = w_sum[64] ? FX_MIN : FX_MAX;
                    end else begin
                        n_res = $signed(w_sum[63:0]);
                    end
                    n_done = 1'b1;
                end
                OP_HALF: begin
                    n_res  = (i_a + $signed({63'd0, i_a[63]})) >>> 1;
                    n_done = 1'b1;
                end
                OP_MUL: begin
                    n_acc  = 128'd0;
                    n_busy = 1'b1;
                end
                OP_DIV: begin
                    if (i_a == 64'sd0) begin
                        n_res  = 64'sd0;
                        n_done = 1'b1;
                    end else if (i_b == 64'sd0) begin
                        n_res  = i_a[63] ? FX_MIN : FX_MAX;
                        n_done = 1'b1;
                    end else begin
                        n_acc  = {32'd0, w_mag_a, 32'd0};
                        n_busy = 1'b1;
                    end
                end
                OP_SQRT: begin
                    if (i_a <= 64'sd0) begin
                        n_res  = 64'sd0;
                        n_done = 1'b1;
                    end else begin
                        n_acc  = {32'd0, i_a, 32'd0};
                        n_neg  = 1'b0;
                        n_busy = 1'b1;
                    end
                end
                default: begin
                    n_res  = 64'sd0;
                    n_done = 1'b1;
                end
            endcase
        end else if (r_busy) begin
            n_cnt = r_cnt + 8'd1;
            case (r_op)
                OP_MUL: begin
                    if (r_cnt == 8'd4) begin
                        n_res  = from_mag(r_neg, r_acc[95:32], |r_acc[127:96]);
                        n_done = 1'b1;
                        n_busy = 1'b0;
                    end else begin
                        n_acc = r_acc + w_pp;
                    end
                end
                OP_DIV: begin
                    if (r_cnt == 8'd128) begin
                        n_res  = from_mag(r_neg, r_q, r_ovf);
                        n_done = 1'b1;
                        n_busy = 1'b0;
                    end else begin
                        n_rem = w_ge ? 64'(w_r2 - {1'b0, r_mb}) : w_r2[63:0];
                        n_ovf = r_ovf | r_q[63];
                        n_q   = {r_q[62:0], w_ge};
                        n_acc = {r_acc[126:0], 1'b0};
                    end
                end
                OP_SQRT: begin
                    if (r_cnt == 8'd48) begin
                        n_res  = from_mag(1'b0, r_q, 1'b0);
                        n_done = 1'b1;
                        n_busy = 1'b0;
                    end else begin
                        if (w_sh >= w_trial) begin
                            n_srem = w_sh - w_trial;
                            n_q    = {r_q[62:0], 1'b1};
                        end else begin
                            n_srem = w_sh;
                            n_q    = {r_q[62:0], 1'b0};
                        end
                        n_acc = {r_acc[125:0], 2'b00};
                    end
                end
                default: begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op   <= n_op;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_srem <= n_srem;
        r_q    <= n_q;
        r_ovf  <= n_ovf;
        r_res  <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("result issued while unit busy");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt <= 8'd128) else $error("step count overrun");
    a_sqrt_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && $past(r_op) == OP_SQRT && $past(r_busy) |-> !r_res[63])
        else $error("negative root");

endmodule
`default_nettype wire

### hdl/rhd_conserved_to_primitive_top.sv
// conserved-to-primitive converter top level: microcoded sequencer over the
// shared fixed point unit rc2p_alu; uses rc2p_pkg
`default_nettype none
// One cell is converted at a time, working values signed Q31.32. The input channel is
// stalled from the transfer of a cell until its result is loaded into the output
// register; the next cell may be taken while that result waits. Every step goes
// through one shared unit, whose bit-serial divider (one quotient bit per cycle) is
// its slowest operation and sets the pace. A cell runs set-up and a first residual,
// then Newton steps (a shorter one when a small step ends the solve), then velocity,
// density and pressure, which are skipped when the solve fails. Configuration is
// written through a plain write port.
module rhd_conserved_to_primitive_top
    import rc2p_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [32:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [62:0]        i_specific_volume,
    input  wire logic signed [63:0] i_momentum,
    input  wire logic signed [63:0] i_total_energy,
    input  wire logic [33:0]        i_adiabatic_index,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [62:0]             o_density,
    output logic signed [33:0]      o_velocity,
    output logic signed [63:0]      o_pressure,
    output logic [3:0]              o_iterations_used,
    output logic                    o_solve_failed
);

    // sequencer steps
    localparam logic [5:0] S_IDLE  = 6'd0;
    localparam logic [5:0] S_U1SQ  = 6'd1;
    localparam logic [5:0] S_GM1   = 6'd2;
    localparam logic [5:0] S_GU2   = 6'd3;
    localparam logic [5:0] S_GU1   = 6'd4;
    localparam logic [5:0] S_GU1SQ = 6'd5;
    localparam logic [5:0] S_H0A   = 6'd6;
    localparam logic [5:0] S_H0B   = 6'd7;
    localparam logic [5:0] S_F_H2  = 6'd8;
    localparam logic [5:0] S_F_RS  = 6'd9;
    localparam logic [5:0] S_F_RQ  = 6'd10;
    localparam logic [5:0] S_F_GH  = 6'd11;
    localparam logic [5:0] S_F_Y1  = 6'd12;
    localparam logic [5:0] S_F_GR  = 6'd13;
    localparam logic [5:0] S_F_Y2  = 6'd14;
    localparam logic [5:0] S_F_Y3  = 6'd15;
    localparam logic [5:0] S_CHECK = 6'd16;
    localparam logic [5:0] S_D_2H  = 6'd17;
    localparam logic [5:0] S_D_GM  = 6'd18;
    localparam logic [5:0] S_D_GH  = 6'd19;
    localparam logic [5:0] S_D_DV  = 6'd20;
    localparam logic [5:0] S_D_DF  = 6'd21;
    localparam logic [5:0] S_N_Q   = 6'd22;
    localparam logic [5:0] S_N_H1  = 6'd23;
    localparam logic [5:0] S_N_D   = 6'd24;
    localparam logic [5:0] S_N_TST = 6'd25;
    localparam logic [5:0] S_FIN   = 6'd26;
    localparam logic [5:0] S_O_HH  = 6'd27;
    localparam logic [5:0] S_O_AD  = 6'd28;
    localparam logic [5:0] S_O_SQ  = 6'd29;
    localparam logic [5:0] S_O_V   = 6'd30;
    localparam logic [5:0] S_O_VC  = 6'd31;
    localparam logic [5:0] S_O_VV  = 6'd32;
    localparam logic [5:0] S_O_1M  = 6'd33;
    localparam logic [5:0] S_O_SR  = 6'd34;
    localparam logic [5:0] S_O_RHO = 6'd35;
    localparam logic [5:0] S_O_HM  = 6'd36;
    localparam logic [5:0] S_O_TG  = 6'd37;
    localparam logic [5:0] S_O_TD  = 6'd38;
    localparam logic [5:0] S_O_P   = 6'd39;
    localparam logic [5:0] S_DONE  = 6'd40;

    // write-back targets
    localparam logic [3:0] D_T     = 4'd0;
    localparam logic [3:0] D_S     = 4'd1;
    localparam logic [3:0] D_Y     = 4'd2;
    localparam logic [3:0] D_R     = 4'd3;
    localparam logic [3:0] D_H     = 4'd4;
    localparam logic [3:0] D_H1    = 4'd5;
    localparam logic [3:0] D_U1SQ  = 4'd6;
    localparam logic [3:0] D_GM1   = 4'd7;
    localparam logic [3:0] D_GU2   = 4'd8;
    localparam logic [3:0] D_GU1SQ = 4'd9;

    // configuration
    logic [32:0] r_tol;
    logic [3:0]  r_maxit;

    // cell working set
    logic [5:0]         r_pc, n_pc;
    logic               r_go;
    logic [3:0]         r_ite;
    logic               r_fail;
    logic signed [63:0] r_u0, r_u1, r_u2, r_g;
    logic signed [63:0] r_u1sq, r_gm1, r_gu2, r_gu1sq;
    logic signed [63:0] r_h, r_h1, r_t, r_s, r_y, r_r;

    // result register
    logic               r_out_valid;
    logic [62:0]        r_out_rho;
    logic signed [33:0] r_out_v;
    logic signed [63:0] r_out_p;
    logic [3:0]         r_out_ite;
    logic               r_out_fail;

    // sequencer decode
    logic               c_isop;
    logic [2:0]         c_op;
    logic signed [63:0] c_a, c_b;
    logic [3:0]         c_dst;
    logic [5:0]         c_next;

    t_alu_req           w_req;
    logic               w_done;
    logic signed [63:0] w_res;
    logic [63:0]        w_mag_y, w_mag_s;
    logic signed [63:0] w_h1c;
    logic               w_in_xfer, w_out_xfer, w_load;

    always_comb begin
        c_isop = 1'b1;
        c_op   = OP_ADD;
        c_a    = r_t;
        c_b    = r_t;
        c_dst  = D_T;
        c_next = S_IDLE;
        case (r_pc)
            S_U1SQ:  begin c_op = OP_MUL;  c_a = r_u1;   c_b = r_u1;    c_dst = D_U1SQ;  c_next = S_GM1;   end
            S_GM1:   begin c_op = OP_SUB;  c_a = r_g;    c_b = ONE_FX;  c_dst = D_GM1;   c_next = S_GU2;   end
            S_GU2:   begin c_op = OP_MUL;  c_a = r_g;    c_b = r_u2;    c_dst = D_GU2;   c_next = S_GU1;   end
            S_GU1:   begin c_op = OP_MUL;  c_a = r_g;    c_b = r_u1;    c_dst = D_T;     c_next = S_GU1SQ; end
            S_GU1SQ: begin c_op = OP_MUL;  c_a = r_t;    c_b = r_u1;    c_dst = D_GU1SQ; c_next = S_H0A;   end
            S_H0A:   begin c_op = OP_ADD;  c_a = ONE_FX; c_b = r_gu2;   c_dst = D_T;     c_next = S_H0B;   end
            S_H0B:   begin c_op = OP_HALF; c_a = r_t;                   c_dst = D_H;     c_next = S_F_H2;  end
            // residual at r_h
            S_F_H2:  begin c_op = OP_MUL;  c_a = r_h;    c_b = r_h;     c_dst = D_T;     c_next = S_F_RS;  end
            S_F_RS:  begin c_op = OP_ADD;  c_a = r_u1sq; c_b = r_t;     c_dst = D_R;     c_next = S_F_RQ;  end
            S_F_RQ:  begin c_op = OP_SQRT; c_a = r_r;                   c_dst = D_R;     c_next = S_F_GH;  end
            S_F_GH:  begin c_op = OP_MUL;  c_a = r_gm1;  c_b = r_h;     c_dst = D_Y;     c_next = S_F_Y1;  end
            S_F_Y1:  begin c_op = OP_ADD;  c_a = r_t;    c_b = r_y;     c_dst = D_Y;     c_next = S_F_GR;  end
            S_F_GR:  begin c_op = OP_MUL;  c_a = r_gu2;  c_b = r_r;     c_dst = D_T;     c_next = S_F_Y2;  end
            S_F_Y2:  begin c_op = OP_SUB;  c_a = r_y;    c_b = r_t;     c_dst = D_Y;     c_next = S_F_Y3;  end
            S_F_Y3:  begin c_op = OP_ADD;  c_a = r_y;    c_b = r_gu1sq; c_dst = D_Y;     c_next = S_CHECK; end
            // derivative, reusing the root kept from the residual at the same h
            S_D_2H:  begin c_op = OP_ADD;  c_a = r_h;    c_b = r_h;     c_dst = D_T;     c_next = S_D_GM;  end
            S_D_GM:  begin c_op = OP_ADD;  c_a = r_t;    c_b = r_gm1;   c_dst = D_T;     c_next = S_D_GH;  end
            S_D_GH:  begin c_op = OP_MUL;  c_a = r_gu2;  c_b = r_h;     c_dst = D_S;     c_next = S_D_DV;  end
            S_D_DV:  begin c_op = OP_DIV;  c_a = r_s;    c_b = r_r;     c_dst = D_S;     c_next = S_D_DF;  end
            S_D_DF:  begin c_op = OP_SUB;  c_a = r_t;    c_b = r_s;     c_dst = D_T;     c_next = S_N_Q;   end
            S_N_Q:   begin c_op = OP_DIV;  c_a = r_y;    c_b = r_t;     c_dst = D_S;     c_next = S_N_H1;  end
            S_N_H1:  begin c_op = OP_SUB;  c_a = r_h;    c_b = r_s;     c_dst = D_H1;    c_next = S_N_D;   end
            S_N_D:   begin c_op = OP_SUB;  c_a = r_h1;   c_b = r_h;     c_dst = D_S;     c_next = S_N_TST; end
            // primitive values
            S_O_HH:  begin c_op = OP_MUL;  c_a = r_h;    c_b = r_h;     c_dst = D_T;     c_next = S_O_AD;  end
            S_O_AD:  begin c_op = OP_ADD;  c_a = r_t;    c_b = r_u1sq;  c_dst = D_T;     c_next = S_O_SQ;  end
            S_O_SQ:  begin c_op = OP_SQRT; c_a = r_t;                   c_dst = D_T;     c_next = S_O_V;   end
            S_O_V:   begin c_op = OP_DIV;  c_a = r_u1;   c_b = r_t;     c_dst = D_S;     c_next = S_O_VC;  end
            S_O_VV:  begin c_op = OP_MUL;  c_a = r_s;    c_b = r_s;     c_dst = D_T;     c_next = S_O_1M;  end
            S_O_1M:  begin c_op = OP_SUB;  c_a = ONE_FX; c_b = r_t;     c_dst = D_T;     c_next = S_O_SR;  end
            S_O_SR:  begin c_op = OP_SQRT; c_a = r_t;                   c_dst = D_T;     c_next = S_O_RHO; end
            S_O_RHO: begin c_op = OP_DIV;  c_a = r_t;    c_b = r_u0;    c_dst = D_Y;     c_next = S_O_HM;  end
            S_O_HM:  begin c_op = OP_SUB;  c_a = r_h;    c_b = ONE_FX;  c_dst = D_T;     c_next = S_O_TG;  end
            S_O_TG:  begin c_op = OP_MUL;  c_a = r_t;    c_b = r_gm1;   c_dst = D_T;     c_next = S_O_TD;  end
            S_O_TD:  begin c_op = OP_DIV;  c_a = r_t;    c_b = r_g;     c_dst = D_T;     c_next = S_O_P;   end
            S_O_P:   begin c_op = OP_MUL;  c_a = r_t;    c_b = r_y;     c_dst = D_T;     c_next = S_DONE;  end
            default: c_isop = 1'b0;
        endcase
    end

    assign w_req.start = c_isop && !r_go;
    assign w_req.op    = c_op;

    rc2p_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (c_a),
        .i_b     (c_b),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    assign w_mag_y = r_y[63] ? 64'(-r_y) : 64'(r_y);
    assign w_mag_s = r_s[63] ? 64'(-r_s) : 64'(r_s);

    // clamp the new iterate: first up to one, then down to the energy bound
    always_comb begin
        w_h1c = (r_h1 < ONE_FX) ? ONE_FX : r_h1;
        if (w_h1c > r_gu2) begin
            w_h1c = r_gu2;
        end
    end

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = r_out_valid && !i_out_stall;
    assign w_load     = (r_pc == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_pc = r_pc;
        case (r_pc)
            S_IDLE:  if (w_in_xfer) n_pc = S_U1SQ;
            S_CHECK: begin
                if (w_mag_y > {31'd0, r_tol} && r_ite < r_maxit) begin
                    n_pc = S_D_2H;
                end else begin
                    n_pc = S_FIN;
                end
            end
            S_N_TST: n_pc = (w_mag_s < {31'd0, r_tol}) ? S_FIN : S_F_H2;
            S_FIN:   n_pc = (r_h < ONE_FX) ? S_DONE : S_O_HH;
            S_O_VC:  n_pc = S_O_VV;
            S_DONE:  if (w_load) n_pc = S_IDLE;
            default: if (c_isop && w_done) n_pc = c_next;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol       <= 33'd1;
            r_maxit     <= 4'd10;
            r_pc        <= S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TOL:   r_tol   <= i_cfg_data;
                    CFG_MAXIT: r_maxit <= i_cfg_data[3:0];
                    default:   r_tol   <= r_tol;
                endcase
            end
            r_pc <= n_pc;
            // shared unit request in flight
            if (c_isop && w_done) begin
                r_go <= 1'b0;
            end else if (c_isop) begin
                r_go <= 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_pc == S_IDLE && w_in_xfer) begin
            r_u0  <= {1'b0, i_specific_volume};
            r_u1  <= i_momentum;
            r_u2  <= i_total_energy;
            r_g   <= {30'd0, i_adiabatic_index};
            r_ite <= 4'd0;
        end
        if (c_isop && w_done) begin
            case (c_dst)
                D_T:     r_t     <= w_res;
                D_S:     r_s     <= w_res;
                D_Y:     r_y     <= w_res;
                D_R:     r_r     <= w_res;
                D_H:     r_h     <= w_res;
                D_H1:    r_h1    <= w_res;
                D_U1SQ:  r_u1sq  <= w_res;
                D_GM1:   r_gm1   <= w_res;
                D_GU2:   r_gu2   <= w_res;
                D_GU1SQ: r_gu1sq <= w_res;
                default: r_t     <= w_res;
            endcase
        end
        if (r_pc == S_N_TST) begin
            if (w_mag_s < {31'd0, r_tol}) begin
                // step small enough: take it unclamped and stop
                r_h <= r_h1;
            end else begin
                r_h   <= w_h1c;
                r_ite <= r_ite + 4'd1;
            end
        end
        if (r_pc == S_FIN) begin
            r_fail <= r_h < ONE_FX;
        end
        // velocity kept within the unit interval
        if (r_pc == S_O_VC) begin
            if (r_s > ONE_FX) begin
                r_s <= ONE_FX;
            end else if (r_s < -ONE_FX) begin
                r_s <= -ONE_FX;
            end
        end
        if (w_load) begin
            r_out_ite  <= r_ite;
            r_out_fail <= r_fail;
            r_out_rho  <= r_fail ? 63'd0 : r_y[62:0];
            r_out_v    <= r_fail ? 34'sd0 : r_s[33:0];
            r_out_p    <= r_fail ? 64'sd0 : r_t;
        end
    end

    assign o_in_stall        = (r_pc != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_density         = r_out_rho;
    assign o_velocity        = r_out_v;
    assign o_pressure        = r_out_p;
    assign o_iterations_used = r_out_ite;
    assign o_solve_failed    = r_out_fail;

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_fail |-> r_out_rho == 63'd0 && r_out_v == 34'sd0
                                      && r_out_p == 64'sd0)
        else $error("failed cell with non-zero result");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_in_xfer) |-> o_in_stall) else $error("transfer taken while busy");
    a_vel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_v <= 34'sh1_0000_0000 && r_out_v >= -34'sh1_0000_0000)
        else $error("velocity outside unit interval");
    a_ite_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> r_ite <= r_maxit) else $error("iteration count above bound");

endmodule
`default_nettype wire

### tb/tb_rhd_conserved_to_primitive_top.sv
// self-checking testbench for rhd_conserved_to_primitive_top: cells are driven over the
// valid/stall input channel, the primitive values are predicted in fixed point and checked
// depends on rc2p_pkg and rhd_conserved_to_primitive_top
`timescale 1ns / 100ps
module tb_rhd_conserved_to_primitive_top;
    import rc2p_pkg::*;

    typedef struct {
        logic [62:0]        vol;
        logic signed [63:0] mom;
        logic signed [63:0] energy;
        logic [33:0]        gamma;
    } cell_in_t;

    typedef struct {
        logic [62:0] density;
        logic [33:0] velocity;
        logic [63:0] pressure;
        logic [3:0]  iters;
        logic        failed;
    } prim_out_t;

    // scoreboard: holds the register copies, predicts each cell and checks the results in order
    class prim_scoreboard;
        logic [32:0]        tol = 33'd1;
        logic [3:0]         maxit = 4'd10;
        int                 errors = 0;
        prim_out_t          pending[$];
        logic signed [63:0] u1sq, gm1, gu2, gu1sq;

        function logic [63:0] mag(logic signed [63:0] a);
            return a[63] ? -a : a;
        endfunction

        function logic signed [63:0] from_mag(bit neg, logic [63:0] m);
            if (!neg) return m[63] ? FX_MAX : m;
            if (m[63]) return FX_MIN;
            return -m;
        endfunction

        function logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [64:0] s;
            s = 65'(a) + 65'(b);
            if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
            return s[63:0];
        endfunction

        function logic signed [63:0] sat_sub(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [64:0] s;
            s = 65'(a) - 65'(b);
            if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
            return s[63:0];
        endfunction

        function logic signed [63:0] fmul(logic signed [63:0] a, logic signed [63:0] b);
            logic [127:0] p;
            p = ({64'd0, mag(a)} * {64'd0, mag(b)}) >> FRAC_BITS;
            return from_mag(a[63] ^ b[63], (|p[127:64]) ? '1 : p[63:0]);
        endfunction

        function logic signed [63:0] fdiv(logic signed [63:0] a, logic signed [63:0] b);
            logic [127:0] q;
            if (a == 0) return 0;
            if (b == 0) return a[63] ? FX_MIN : FX_MAX;
            q = ({64'd0, mag(a)} << FRAC_BITS) / {64'd0, mag(b)};
            return from_mag(a[63] ^ b[63], (|q[127:64]) ? '1 : q[63:0]);
        endfunction

        // floor of the exact root of a scaled by one fraction shift
        function logic signed [63:0] fsqrt(logic signed [63:0] a);
            logic [127:0] x, r, c;
            if (a <= 0) return 0;
            x = {64'd0, a} << FRAC_BITS;
            r = 0;
            for (int i = 63; i >= 0; i--) begin
                c = r | (128'd1 << i);
                if (c * c <= x) r = c;
            end
            return from_mag(1'b0, r[63:0]);
        endfunction

        function logic signed [63:0] residual(logic signed [63:0] h);
            logic signed [63:0] h2, rt, acc;
            h2 = fmul(h, h);
            rt = fsqrt(sat_add(u1sq, h2));
            acc = sat_add(h2, fmul(gm1, h));
            acc = sat_sub(acc, fmul(gu2, rt));
            return sat_add(acc, gu1sq);
        endfunction

        function logic signed [63:0] slope(logic signed [63:0] h);
            logic signed [63:0] rt, acc;
            rt = fsqrt(sat_add(u1sq, fmul(h, h)));
            acc = sat_add(sat_add(h, h), gm1);
            return sat_sub(acc, fdiv(fmul(gu2, h), rt));
        endfunction

        function prim_out_t convert_cell(cell_in_t c);
            logic signed [63:0] u0, u1, g, hmax, h, h1, y, v, rho, p;
            logic [3:0]         n;
            prim_out_t          o;
            u0 = {1'b0, c.vol};
            u1 = c.mom;
            g = {30'd0, c.gamma};
            u1sq = fmul(u1, u1);
            gm1 = sat_sub(g, ONE_FX);
            gu2 = fmul(g, c.energy);
            gu1sq = fmul(fmul(g, u1), u1);
            hmax = gu2;
            h = sat_add(ONE_FX, hmax) / 64'sd2;
            y = residual(h);
            n = 0;
            while (mag(y) > {31'd0, tol} && n < maxit) begin
                h1 = sat_sub(h, fdiv(y, slope(h)));
                // small step: accept the unclamped iterate and stop
                if (mag(sat_sub(h1, h)) < {31'd0, tol}) begin
                    h = h1;
                    break;
                end
                if (h1 < ONE_FX) h1 = ONE_FX;
                if (h1 > hmax) h1 = hmax;
                y = residual(h1);
                h = h1;
                n++;
            end
            v = 0;
            rho = 0;
            p = 0;
            o.failed = h < ONE_FX;
            if (!o.failed) begin
                v = fdiv(u1, fsqrt(sat_add(fmul(h, h), u1sq)));
                if (v > ONE_FX) v = ONE_FX;
                if (v < -ONE_FX) v = -ONE_FX;
                rho = fdiv(fsqrt(sat_sub(ONE_FX, fmul(v, v))), u0);
                p = fmul(fdiv(fmul(sat_sub(h, ONE_FX), gm1), g), rho);
            end
            o.density = rho[62:0];
            o.velocity = v[33:0];
            o.pressure = p;
            o.iters = n;
            return o;
        endfunction

        function void note_cell(cell_in_t c);
            pending.push_back(convert_cell(c));
        endfunction

        function void check_result(prim_out_t got);
            prim_out_t want;
            if (pending.size() == 0) begin
                $error("result with no cell outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.density !== want.density) begin
                $error("density: expected %h, got %h", want.density, got.density);
                errors++;
            end
            if (got.velocity !== want.velocity) begin
                $error("velocity: expected %h, got %h", want.velocity, got.velocity);
                errors++;
            end
            if (got.pressure !== want.pressure) begin
                $error("pressure: expected %h, got %h", want.pressure, got.pressure);
                errors++;
            end
            if (got.iters !== want.iters) begin
                $error("iterations_used: expected %0d, got %0d", want.iters, got.iters);
                errors++;
            end
            if (got.failed !== want.failed) begin
                $error("solve_failed: expected %b, got %b", want.failed, got.failed);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = CFG_TOL;
    logic [32:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [62:0]        i_specific_volume = '0;
    logic signed [63:0] i_momentum = '0;
    logic signed [63:0] i_total_energy = '0;
    logic [33:0]        i_adiabatic_index = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [62:0]        o_density;
    logic signed [33:0] o_velocity;
    logic signed [63:0] o_pressure;
    logic [3:0]         o_iterations_used;
    logic               o_solve_failed;

    rhd_conserved_to_primitive_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_specific_volume(i_specific_volume), .i_momentum(i_momentum),
        .i_total_energy(i_total_energy), .i_adiabatic_index(i_adiabatic_index),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_density(o_density), .o_velocity(o_velocity), .o_pressure(o_pressure),
        .o_iterations_used(o_iterations_used), .o_solve_failed(o_solve_failed)
    );

    prim_scoreboard sb = new();
    int             tx_idle_pct = 0;  // chance in a hundred that the sender holds off a cycle
    int             rx_idle_pct = 0;  // chance in a hundred that the receiver stalls a cycle
    int             cells_sent = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // generous backstop: far beyond the slowest correct run
    initial begin
        #1_000_000_000;
        $display("rhd_conserved_to_primitive_top regression: fail");
        $finish;
    end

    // result side: sample at the edge, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        prim_out_t got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.density = o_density;
            got.velocity = o_velocity;
            got.pressure = o_pressure;
            got.iters = o_iterations_used;
            got.failed = o_solve_failed;
            sb.check_result(got);
        end
        i_out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // idling pattern follows progress through the run: sender light / receiver heavy,
    // then the other way round, then no idling at all
    function void pick_idling();
        if (cells_sent < 430) begin
            tx_idle_pct = 6;
            rx_idle_pct = 76;
        end else if (cells_sent < 860) begin
            tx_idle_pct = 76;
            rx_idle_pct = 6;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endfunction

    // one cell over the input channel; returns just after the edge of its transfer
    task send_cell(input cell_in_t c);
        pick_idling();
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_specific_volume <= c.vol;
        i_momentum <= c.mom;
        i_total_energy <= c.energy;
        i_adiabatic_index <= c.gamma;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_cell(c);
        cells_sent++;
    endtask

    // register write only once the block has drained
    task write_reg(input logic idx, input logic [32:0] val);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == CFG_TOL) sb.tol = val;
        else sb.maxit = val[3:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function cell_in_t make_cell(logic [62:0] vol, logic signed [63:0] mom,
                                 logic signed [63:0] energy, logic [33:0] gamma);
        cell_in_t c;
        c.vol = vol;
        c.mom = mom;
        c.energy = energy;
        c.gamma = gamma;
        return c;
    endfunction

    // mostly physical cells with random content, some raw noise and some broken ones
    function cell_in_t random_cell();
        cell_in_t     c;
        int unsigned  sel, e_int;
        logic [63:0]  m;
        sel = $urandom_range(99);
        e_int = $urandom_range(1, 40);
        c.vol = 63'({$urandom_range(0, 100), $urandom});
        if ($urandom_range(9) == 0) c.vol = {31'd0, $urandom};
        c.gamma = {2'b01, $urandom};
        if (c.gamma == 34'h1_0000_0000) c.gamma = 34'h2_0000_0000;
        c.energy = {32'(e_int), $urandom};
        m = {32'($urandom_range(0, e_int - 1)), $urandom};
        c.mom = $urandom_range(1) ? -$signed(m) : $signed(m);
        if (sel < 10) begin
            c.vol = 63'({$urandom, $urandom});
            c.mom = {$urandom, $urandom};
            c.energy = {$urandom, $urandom};
            c.gamma = 34'({$urandom, $urandom});
        end else if (sel < 17) begin
            // momentum beyond the energy, or energy below rest mass
            c.mom = {32'($urandom_range(0, 200)) - 32'd100, $urandom};
            c.energy = {32'($urandom_range(0, 4)) - 32'd2, $urandom};
        end else if (sel < 20) begin
            c.vol = '0;
        end
        return c;
    endfunction

    task run_random(input int count);
        for (int k = 0; k < count; k++) send_cell(random_cell());
    endtask

    initial begin
        cell_in_t directed[$];
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed cells under the reset register values
        directed.push_back(make_cell(63'h1_0000_0000, 64'sd0, 64'sh2_0000_0000,
                                     34'h1_AAAA_AAAB));
        directed.push_back(make_cell(63'h2_0000_0000, 64'sh8000_0000,
                                     64'sh3_0000_0000, 34'h1_5555_5555));
        directed.push_back(make_cell(63'h1_0000_0000, -64'sh8000_0000,
                                     64'sh3_0000_0000, 34'h2_0000_0000));
        // zero specific volume: largest density
        directed.push_back(make_cell(63'd0, 64'sh4000_0000, 64'sh2_0000_0000,
                                     34'h1_6666_6666));
        directed.push_back(make_cell('1, 64'sh1_0000_0000, 64'sh5_0000_0000, 34'h1_0000_0001));
        directed.push_back(make_cell(63'd1, 64'sd0, 64'sh1_0000_0001, 34'h2_0000_0000));
        // failed solves (energy negative or zero) and extremes: saturated momentum or energy, momentum beyond energy
        directed.push_back(make_cell(63'h1_0000_0000, 64'sd0, -64'sh2_0000_0000,
                                     34'h1_AAAA_AAAB));
        directed.push_back(make_cell(63'h1_0000_0000, 64'sh1_0000_0000, 64'sd0,
                                     34'h1_AAAA_AAAB));
        directed.push_back(make_cell(63'h1_0000_0000, FX_MAX, FX_MAX, 34'h1_8000_0000));
        directed.push_back(make_cell(63'h1_0000_0000, FX_MIN, FX_MAX, 34'h1_8000_0000));
        directed.push_back(make_cell(63'h1_0000_0000, FX_MIN, FX_MIN, 34'h1_8000_0000));
        directed.push_back(make_cell(63'h1_0000_0000, 64'sh10_0000_0000,
                                     64'sh2_0000_0000, 34'h1_8000_0000));
        // adiabatic index outside (1, 2]
        directed.push_back(make_cell(63'h1_0000_0000, 64'sh1_0000_0000,
                                     64'sh3_0000_0000, 34'd0));
        directed.push_back(make_cell(63'h1_0000_0000, 64'sh1_0000_0000,
                                     64'sh3_0000_0000, 34'h1_0000_0000));
        directed.push_back(make_cell(63'h1_0000_0000, 64'sh1_0000_0000,
                                     64'sh3_0000_0000, '1));
        // near light speed: velocity rounding at the clamp
        directed.push_back(make_cell(63'h1_0000_0000, 64'sh7FFF_FFFF_0000_0000,
                                     64'sh7FFF_FFFF_8000_0000, 34'h1_8000_0000));
        directed.push_back(make_cell(63'h1_0000_0000, 64'sh0_0000_0001,
                                     64'sh0_0000_0001, 34'h1_0000_0001));
        foreach (directed[k]) send_cell(directed[k]);
        run_random(380);

        // zero tolerance with the deepest iteration bound
        write_reg(CFG_TOL, 33'd0);
        write_reg(CFG_MAXIT, 4'd15);
        run_random(150);
        // zero iteration bound: the start value is judged as it is
        write_reg(CFG_TOL, 33'h1_0000_0000);
        write_reg(CFG_MAXIT, 4'd0);
        run_random(200);
        write_reg(CFG_TOL, '1);
        write_reg(CFG_MAXIT, 4'd1);
        run_random(150);
        write_reg(CFG_TOL, 33'd65536);
        write_reg(CFG_MAXIT, 4'd4);
        run_random(200);
        write_reg(CFG_TOL, {1'b0, $urandom_range(0, 4096)});
        write_reg(CFG_MAXIT, 4'($urandom_range(1, 15)));
        run_random(200);

        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("rhd_conserved_to_primitive_top regression: pass");
        end else begin
            $display("rhd_conserved_to_primitive_top regression: fail");
        end
        $finish;
    end

endmodule
